@@ hdl/mffe_pkg.sv @@
// ----------------------------------------------------------------------------
// mffe_pkg
// Types and constants shared by the magnetic form factor evaluator.
// ----------------------------------------------------------------------------
package mffe_pkg;

  typedef struct packed {
    logic               action;
    logic signed [31:0] q_x;
    logic signed [31:0] q_y;
    logic signed [31:0] q_z;
    logic        [3:0]  material;
    logic        [4:0]  coeff_index;
    logic signed [31:0] coeff_value;
  } mffe_in_t;

  typedef struct packed {
    logic signed [31:0] ff_value;
    logic               saturated;
  } mffe_out_t;

  localparam logic ACT_EVAL  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // coefficient slot within one order
  localparam logic [2:0] K_G = 3'd0;
  localparam logic [2:0] K_D = 3'd7;

  localparam logic [31:0] Q30_ONE   = 32'd1073741824;
  localparam logic [28:0] LOG2E_Q28 = 29'd387270501;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;

  // 2^(k/4) in Q30
  localparam logic [30:0] POW2_QTR [4] = '{
    31'd1073741824, 31'd1276901417, 31'd1518500250, 31'd1805811301
  };

  // floor(2^32 / k) for the Horner divisors
  localparam logic [31:0] RECIP_TBL [8] = '{
    32'd0, 32'd0, 32'd2147483648, 32'd1431655765,
    32'd1073741824, 32'd858993459, 32'd715827882, 32'd0
  };

endpackage

@@ hdl/magnetic_form_factor_eval_core.sv @@
// ----------------------------------------------------------------------------
// magnetic_form_factor_eval_core
// Dipole-approximation magnetic form factor, signed fixed point, with a
// per-material coefficient table.
// ----------------------------------------------------------------------------
// A write beat (action set) stores one coefficient if its material is in
// range and returns nothing. An evaluate beat returns one result beat (zero
// when the material is out of range): every product, including the six
// Horner steps of each of the twelve exponentials, passes through a single
// registered multiplier, and coefficients come from a table with a
// registered read. Input is stalled while an evaluation runs; a finished
// result waits in the output register while the next beat is taken. The
// table has no reset; entries must be written before they are used.
module magnetic_form_factor_eval_core #(
  parameter int MATERIALS = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mffe_pkg::mffe_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mffe_pkg::mffe_out_t out_data_o
);
  import mffe_pkg::*;

  localparam int ADDR_W = $clog2(MATERIALS) + 5;
  localparam int DEPTH  = MATERIALS * 32;
  localparam int MUL_W  = (FRAC_BITS + 7 > 33) ? FRAC_BITS + 7 : 33;
  localparam int PW     = 2 * MUL_W;

  localparam logic signed [PW-1:0] CLIP_HI = PW'(64'sd2147483647);
  localparam logic signed [PW-1:0] CLIP_LO = -CLIP_HI - PW'(1);
  localparam logic signed [PW-1:0] Y_HI    = PW'(22) <<< FRAC_BITS;
  localparam logic signed [PW-1:0] Y_LO    = -(PW'(32) <<< FRAC_BITS);

  typedef enum logic [26:0] {
    ST_IDLE  = 27'd1 << 0,
    ST_SQ0   = 27'd1 << 1,
    ST_SQ1   = 27'd1 << 2,
    ST_SQ2   = 27'd1 << 3,
    ST_SQ3   = 27'd1 << 4,
    ST_SC0   = 27'd1 << 5,
    ST_SC1   = 27'd1 << 6,
    ST_SC2   = 27'd1 << 7,
    ST_RATE  = 27'd1 << 8,
    ST_EY    = 27'd1 << 9,
    ST_E0    = 27'd1 << 10,
    ST_E1    = 27'd1 << 11,
    ST_E2    = 27'd1 << 12,
    ST_HM    = 27'd1 << 13,
    ST_HD    = 27'd1 << 14,
    ST_HF    = 27'd1 << 15,
    ST_E3    = 27'd1 << 16,
    ST_E4    = 27'd1 << 17,
    ST_AMPRD = 27'd1 << 18,
    ST_AMP   = 27'd1 << 19,
    ST_ACC   = 27'd1 << 20,
    ST_DADD  = 27'd1 << 21,
    ST_GP    = 27'd1 << 22,
    ST_GPM   = 27'd1 << 23,
    ST_FIN   = 27'd1 << 24,
    ST_TOT   = 27'd1 << 25,
    ST_DONE  = 27'd1 << 26
  } mffe_state_e;

  function automatic logic [32:0] clip32(input logic signed [PW-1:0] v);
    logic [32:0] r;
    if (v > CLIP_HI) begin
      r = {1'b1, CLIP_HI[31:0]};
    end else if (v < CLIP_LO) begin
      r = {1'b1, CLIP_LO[31:0]};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  mffe_state_e state_q, state_d;

  logic [31:0] coef_mem [DEPTH];
  logic [31:0] rd_q;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [1:0] rd_ord;
  logic [2:0] rd_sel;
  logic mem_we;

  logic signed [MUL_W-1:0] op_a, op_b;
  logic signed [PW-1:0] prod_q;

  logic [31:0] scale_q, scale_d;
  logic [31:0] mx_q, my_q, mz_q, mx_d, my_d, mz_d;
  logic [3:0]  mat_q, mat_d;
  logic [63:0] sum_q, sum_d;
  logic [31:0] tmp_q, tmp_d;
  logic [30:0] ssq_q, ssq_d;
  logic signed [PW-1:0] y_q, y_d;
  logic signed [7:0] n_q, n_d;
  logic [1:0]  ftop_q, ftop_d;
  logic [27:0] t_q, t_d;
  logic [31:0] r_q, r_d;
  logic [2:0]  k_q, k_d;
  logic [29:0] x_q, x_d;
  logic [30:0] e_q, e_d;
  logic signed [34:0] br_q, br_d, tot_q, tot_d;
  logic signed [31:0] gp_q, gp_d, res_q, res_d;
  logic [1:0]  ord_q, ord_d, term_q, term_d;
  logic        sat_q, sat_d;
  logic        out_valid_q, out_valid_d;
  mffe_out_t   out_q, out_d;

  logic in_acc, mat_ok, out_free;
  logic signed [PW-1:0] prod_fb, zs;
  logic [32:0] c_prod, c_br, c_res;
  logic signed [34:0] tot_new;
  logic [64:0] tsum, tsh;
  logic [29:0] q0, hf_rem, q_fix;
  logic [33:0] mant;
  logic signed [9:0] s_sh, s_neg;
  logic [63:0] e_sh;
  logic signed [31:0] coef;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign mat_ok     = 32'(in_data_i.material) < 32'(MATERIALS);
  assign mem_we     = in_acc && (in_data_i.action == ACT_WRITE) && mat_ok;
  assign wr_addr    = ADDR_W'({in_data_i.material, in_data_i.coeff_index});
  assign rd_addr    = ADDR_W'({mat_q, rd_ord, rd_sel});
  assign out_free   = !out_valid_q || !out_stall_i;
  assign coef       = $signed(rd_q);

  assign prod_fb = prod_q >>> FRAC_BITS;
  assign zs      = prod_q >>> (FRAC_BITS - 2);
  assign c_prod  = clip32(prod_fb);
  assign c_br    = clip32(PW'(br_q + 35'($signed(coef))));
  assign tot_new = tot_q + 35'($signed(c_prod[31:0]));
  assign c_res   = clip32(PW'(tot_new >>> 1));
  assign tsum    = 65'(prod_q[63:0]) + 65'(tmp_q);
  assign tsh     = tsum >> (FRAC_BITS - 8);
  assign q0      = prod_q[61:32];
  assign hf_rem  = x_q - 30'(q0 * 30'(k_q));
  assign q_fix   = (hf_rem >= 30'(k_q)) ? q0 + 30'd1 : q0;
  assign mant    = prod_q[63:30];
  assign s_sh    = 10'(30 - FRAC_BITS) - 10'(n_q);
  assign s_neg   = -s_sh;

  always_comb begin
    if (s_sh >= 10'sd63) begin
      e_sh = '0;
    end else if (s_sh > 10'sd0) begin
      e_sh = 64'(mant) >> s_sh[5:0];
    end else begin
      e_sh = 64'(mant) << s_neg[5:0];
    end
  end

  always_comb begin
    state_d = state_q;
    op_a = '0;
    op_b = '0;
    rd_ord = ord_q;
    rd_sel = K_G;
    scale_d = cfg_we_i ? cfg_data_i : scale_q;
    mx_d = mx_q; my_d = my_q; mz_d = mz_q; mat_d = mat_q;
    sum_d = sum_q; tmp_d = tmp_q; ssq_d = ssq_q; y_d = y_q;
    n_d = n_q; ftop_d = ftop_q; t_d = t_q; r_d = r_q; k_d = k_q;
    x_d = x_q; e_d = e_q; br_d = br_q; tot_d = tot_q; gp_d = gp_q;
    res_d = res_q; ord_d = ord_q; term_d = term_q; sat_d = sat_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && in_data_i.action == ACT_EVAL) begin
          mx_d  = mag32(in_data_i.q_x);
          my_d  = mag32(in_data_i.q_y);
          mz_d  = mag32(in_data_i.q_z);
          mat_d = in_data_i.material;
          sat_d = 1'b0;
          res_d = '0;
          state_d = mat_ok ? ST_SQ0 : ST_DONE;
        end
      end
      ST_SQ0: begin
        op_a = MUL_W'(mx_q); op_b = MUL_W'(mx_q);
        state_d = ST_SQ1;
      end
      ST_SQ1: begin
        sum_d = prod_q[63:0];
        op_a = MUL_W'(my_q); op_b = MUL_W'(my_q);
        state_d = ST_SQ2;
      end
      ST_SQ2: begin
        sum_d = sum_q + prod_q[63:0];
        op_a = MUL_W'(mz_q); op_b = MUL_W'(mz_q);
        state_d = ST_SQ3;
      end
      ST_SQ3: begin
        sum_d = sum_q + prod_q[63:0];
        state_d = ST_SC0;
      end
      ST_SC0: begin
        op_a = MUL_W'(sum_q[31:0]); op_b = MUL_W'(scale_q);
        state_d = ST_SC1;
      end
      ST_SC1: begin
        tmp_d = prod_q[63:32];
        op_a = MUL_W'(sum_q[63:32]); op_b = MUL_W'(scale_q);
        state_d = ST_SC2;
      end
      ST_SC2: begin
        if (tsh > 65'h7FFF_FFFF) begin
          ssq_d = '1;
          sat_d = 1'b1;
        end else begin
          ssq_d = tsh[30:0];
        end
        ord_d = '0; term_d = '0; br_d = '0; tot_d = '0;
        rd_ord = '0;
        rd_sel = 3'd2;
        state_d = ST_RATE;
      end
      ST_RATE: begin
        op_a = MUL_W'(coef); op_b = MUL_W'(ssq_q);
        state_d = ST_EY;
      end
      ST_EY: begin
        y_d = -prod_fb;
        state_d = ST_E0;
      end
      ST_E0: begin
        if (y_q >= Y_HI) begin
          e_d = '1;
          sat_d = 1'b1;
          state_d = ST_AMPRD;
        end else if (y_q <= Y_LO) begin
          e_d = '0;
          state_d = ST_AMPRD;
        end else begin
          op_a = $signed(y_q[MUL_W-1:0]); op_b = MUL_W'(LOG2E_Q28);
          state_d = ST_E1;
        end
      end
      ST_E1: begin
        n_d = zs[37:30];
        ftop_d = zs[29:28];
        op_a = MUL_W'(zs[27:0]); op_b = MUL_W'(LN2_Q30);
        state_d = ST_E2;
      end
      ST_E2: begin
        t_d = prod_q[57:30];
        r_d = Q30_ONE;
        k_d = 3'd6;
        state_d = ST_HM;
      end
      ST_HM: begin
        op_a = MUL_W'(t_q); op_b = MUL_W'(r_q);
        state_d = ST_HD;
      end
      ST_HD: begin
        x_d = prod_q[59:30];
        if (k_q == 3'd1) begin
          r_d = Q30_ONE + 32'(prod_q[59:30]);
          state_d = ST_E3;
        end else begin
          op_a = MUL_W'(prod_q[59:30]); op_b = MUL_W'(RECIP_TBL[k_q]);
          state_d = ST_HF;
        end
      end
      ST_HF: begin
        r_d = Q30_ONE + 32'(q_fix);
        k_d = k_q - 3'd1;
        state_d = ST_HM;
      end
      ST_E3: begin
        op_a = MUL_W'(POW2_QTR[ftop_q]); op_b = MUL_W'(r_q);
        state_d = ST_E4;
      end
      ST_E4: begin
        if (e_sh > 64'd2147483647) begin
          e_d = '1;
          sat_d = 1'b1;
        end else begin
          e_d = e_sh[30:0];
        end
        state_d = ST_AMPRD;
      end
      ST_AMPRD: begin
        rd_sel = {term_q, 1'b1};
        state_d = ST_AMP;
      end
      ST_AMP: begin
        op_a = MUL_W'(coef); op_b = MUL_W'(e_q);
        state_d = ST_ACC;
      end
      ST_ACC: begin
        br_d = br_q + 35'($signed(c_prod[31:0]));
        sat_d = sat_q | c_prod[32];
        if (term_q == 2'd2) begin
          rd_sel = K_D;
          state_d = ST_DADD;
        end else begin
          term_d = term_q + 2'd1;
          rd_sel = {term_q + 2'd1, 1'b0} + 3'd2;
          state_d = ST_RATE;
        end
      end
      ST_DADD: begin
        br_d = 35'($signed(c_br[31:0]));
        sat_d = sat_q | c_br[32];
        rd_sel = K_G;
        state_d = ST_GP;
      end
      ST_GP: begin
        if (ord_q == 2'd0) begin
          gp_d = coef;
          state_d = ST_FIN;
        end else begin
          op_a = MUL_W'(coef); op_b = MUL_W'(ssq_q);
          state_d = ST_GPM;
        end
      end
      ST_GPM: begin
        gp_d = $signed(c_prod[31:0]);
        sat_d = sat_q | c_prod[32];
        state_d = ST_FIN;
      end
      ST_FIN: begin
        op_a = MUL_W'(gp_q); op_b = MUL_W'($signed(br_q[31:0]));
        state_d = ST_TOT;
      end
      ST_TOT: begin
        if (ord_q == 2'd3) begin
          res_d = $signed(c_res[31:0]);
          sat_d = sat_q | c_prod[32] | c_res[32];
          state_d = ST_DONE;
        end else begin
          tot_d = tot_new;
          sat_d = sat_q | c_prod[32];
          ord_d = ord_q + 2'd1;
          term_d = '0;
          br_d = '0;
          rd_ord = ord_q + 2'd1;
          rd_sel = 3'd2;
          state_d = ST_RATE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_d.ff_value = res_q;
          out_d.saturated = sat_q;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      coef_mem[wr_addr] <= in_data_i.coeff_value;
    end
    rd_q <= coef_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      scale_q     <= '0;
      k_q         <= '0;
      ord_q       <= '0;
      term_q      <= '0;
      sat_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      scale_q     <= scale_d;
      k_q         <= k_d;
      ord_q       <= ord_d;
      term_q      <= term_d;
      sat_q       <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    mx_q   <= mx_d;
    my_q   <= my_d;
    mz_q   <= mz_d;
    mat_q  <= mat_d;
    sum_q  <= sum_d;
    tmp_q  <= tmp_d;
    ssq_q  <= ssq_d;
    y_q    <= y_d;
    n_q    <= n_d;
    ftop_q <= ftop_d;
    t_q    <= t_d;
    r_q    <= r_d;
    x_q    <= x_d;
    e_q    <= e_d;
    br_q   <= br_d;
    tot_q  <= tot_d;
    gp_q   <= gp_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_horner_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HM) |-> (k_q != 3'd0 && k_q <= 3'd6))
    else $error("horner divisor out of range");

  a_recip_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HF) |-> (hf_rem < 30'({k_q, 1'b0})))
    else $error("reciprocal quotient off by more than one");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_IDLE))
    else $error("table write outside idle");

  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("result beat not presented");

endmodule
